// ----- rtl/core/text_extents_measure_unit_assert.svh -----
// ----------------------------------------------------------------------------
// text_extents_measure_unit_assert
// Assertion macros for the text extents measure unit.
// ----------------------------------------------------------------------------
`ifndef TEXT_EXTENTS_MEASURE_UNIT_ASSERT_SVH
`define TEXT_EXTENTS_MEASURE_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define TEM_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error(msg);
// Next-cycle implication.
`define TEM_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error(msg);
`endif

// ----- rtl/core/tem_pkg.sv -----
// ----------------------------------------------------------------------------
// tem_pkg
// Constants shared by the text extents measure unit.
// ----------------------------------------------------------------------------
package tem_pkg;
	localparam int MaxRanges = 16;
	localparam int MaxGlyphs = 1024;
	localparam int RangeAw = $clog2(MaxRanges);
	localparam int GlyphAw = $clog2(MaxGlyphs);
	localparam int GlyphW = 80;
	localparam int RangeW = 27;

	localparam logic [1:0] CmdRange = 2'd0;
	localparam logic [1:0] CmdGlyph = 2'd1;
	localparam logic [1:0] CmdText = 2'd2;

	localparam logic [1:0] RegLineHeight = 2'd0;
	localparam logic [1:0] RegAlign = 2'd1;
	localparam logic [1:0] RegRanges = 2'd2;

	localparam logic [15:0] CodeNl = 16'd10;
	localparam logic [15:0] CodeHalfNl = 16'd11;
	localparam logic [15:0] CodeBad = 16'd63;
	localparam logic signed [31:0] BoxMinInit = 32'sd65535;
	localparam logic signed [31:0] BoxMaxInit = -32'sd65535;
endpackage

// ----- rtl/core/tem_ram.sv -----
// ----------------------------------------------------------------------------
// tem_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tem_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/core/text_extents_measure_unit.sv -----
// ----------------------------------------------------------------------------
// text_extents_measure_unit
// Bounding box of a UTF-8 string measured against loaded bitmap font metrics.
// ----------------------------------------------------------------------------
// Usage:
//  in channel (in_valid/in_stall): cmd 0 loads a code range into slot,
//  cmd 1 loads glyph metrics into a flat glyph slot, cmd 2 feeds a text byte.
//  Loads are taken one per cycle while idle. A text byte stalls the input
//  through decode, one range read wait, a step per range walked (up
//  to 16), glyph read and draw; the next item is taken the cycle after.
//  Newline and code 11 pass through decode and the line end step. A bad
//  continuation byte handles '?' first, then redecodes the byte.
//  The range walk over the range RAM sets the rate.
//  out channel (out_valid/out_stall): a NUL ends the string and loads the
//  output register with the box; the next string starts at once. While a
//  result waits, more bytes are taken; a second NUL holds until it drains.
//  cfg channel (cfg_valid/cfg_ready): writes line pitch, align mode and
//  range count; always ready, write only while idle.
//  Reset clears text state, align, range count and out_valid, sets pitch 16;
//  the range and glyph RAMs are not cleared and must be loaded before use.
module text_extents_measure_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [9:0]  slot,
	input  logic [7:0]  text_byte,
	input  logic [15:0] range_first,
	input  logic [10:0] range_size,
	input  logic [15:0] glyph_width,
	input  logic [15:0] glyph_height,
	input  logic signed [15:0] glyph_dx,
	input  logic signed [15:0] glyph_dy,
	input  logic signed [15:0] glyph_advance,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] box_width,
	output logic [31:0] box_height,
	output logic signed [31:0] origin_x,
	output logic signed [31:0] origin_y,
	output logic [31:0] baseline_offset,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import tem_pkg::*;
	`include "text_extents_measure_unit_assert.svh"

	typedef enum logic [6:0] {
		StIdle  = 7'b0000001,
		StDec   = 7'b0000010,
		StWalk  = 7'b0000100,
		StGlyph = 7'b0001000,
		StDraw  = 7'b0010000,
		StEnd   = 7'b0100000,
		StEmit  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [15:0] line_pitch_q;
	logic [3:0]  align_q;
	logic [4:0]  ranges_q;
	logic [1:0]  pend_q;
	logic [15:0] part_q;
	logic [31:0] pen_x_q, pen_y_q;
	logic signed [31:0] lmin_q, lmax_q;
	logic ink_q;
	logic signed [31:0] bx0_q, by0_q, bx1_q, by1_q;
	logic [7:0]  byte_q;
	logic        redo_q;    // re-decode byte_q after '?'
	logic [15:0] code_q;
	logic [1:0]  after_q;   // what the code does: 0 glyph, 1 nl, 2 half nl, 3 end; in the walk, 1 marks the read issued
	logic [4:0]  ri_q;
	logic [15:0] base_q;    // sum of sizes of the ranges passed
	logic [GlyphAw-1:0] gidx_q;

	// ---- memories ----
	logic [RangeAw-1:0] r_raddr;
	logic [RangeW-1:0]  r_rdata;
	logic [GlyphW-1:0]  g_rdata;
	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	tem_ram #(.Width(RangeW), .Depth(MaxRanges)) u_range_ram (
		.clk, .we(in_acc && cmd == CmdRange && slot < 10'(MaxRanges)),
		.waddr(slot[RangeAw-1:0]), .wdata({range_first, range_size}),
		.raddr(r_raddr), .rdata(r_rdata));
	tem_ram #(.Width(GlyphW), .Depth(MaxGlyphs)) u_glyph_ram (
		.clk, .we(in_acc && cmd == CmdGlyph),
		.waddr(slot[GlyphAw-1:0]),
		.wdata({glyph_width, glyph_height, glyph_dx, glyph_dy, glyph_advance}),
		.raddr(gidx_q), .rdata(g_rdata));

	// ---- decode of one byte against the pending sequence ----
	logic [7:0] b;
	assign b = byte_q;
	logic        d_code;   // a code comes out
	logic [15:0] d_val;
	logic        d_redo;
	logic [1:0]  d_pend;
	logic [15:0] d_part;
	always_comb begin
		d_code = 1'b0; d_val = '0; d_redo = 1'b0; d_pend = pend_q; d_part = part_q;
		if (pend_q != 2'd0 && !redo_q) begin
			if (b == 8'd0) begin
				d_code = 1'b1; d_pend = 2'd0;
			end else if (b[7:6] == 2'b10) begin
				d_part = {part_q[9:0], b[5:0]};
				d_pend = pend_q - 2'd1;
				if (pend_q == 2'd1) begin
					d_code = 1'b1; d_val = d_part;
				end
			end else begin
				d_code = 1'b1; d_val = CodeBad; d_redo = 1'b1; d_pend = 2'd0;
			end
		end else if (!b[7]) begin
			d_code = 1'b1; d_val = {8'd0, b};
		end else if (b[7:5] == 3'b110) begin
			d_pend = 2'd1; d_part = {11'd0, b[4:0]};
		end else if (b[7:4] == 4'b1110) begin
			d_pend = 2'd2; d_part = {12'd0, b[3:0]};
		end else begin
			d_code = 1'b1; d_val = CodeBad;
		end
	end

	logic [4:0] n_ranges;
	assign n_ranges = (ranges_q > 5'(MaxRanges)) ? 5'(MaxRanges) : ranges_q;

	// ---- range compare ----
	logic [15:0] rf;
	logic [10:0] rs;
	logic [16:0] r_end;
	logic [16:0] g_sum;
	assign rf = r_rdata[26:11];
	assign rs = r_rdata[10:0];
	assign r_end = {1'b0, rf} + {6'd0, rs};
	assign g_sum = {1'b0, base_q} + {1'b0, code_q - rf};

	// read address runs one range ahead when the walk passes a range
	logic walk_first, walk_pass;
	logic [4:0] ri_nxt;
	assign walk_first = (ri_q == 5'd0) && (base_q == 16'd0) && (after_q == 2'd0);
	assign walk_pass = (state_q == StWalk) && !walk_first && (ri_q < n_ranges)
		&& ({1'b0, rf} <= {1'b0, code_q}) && ({1'b0, code_q} >= r_end);
	assign ri_nxt = ri_q + 5'd1;
	assign r_raddr = walk_pass ? ri_nxt[RangeAw-1:0] : ri_q[RangeAw-1:0];

	// ---- glyph draw ----
	logic [15:0] gw, gh;
	logic signed [15:0] gdx, gdy, gadv;
	assign {gw, gh, gdx, gdy, gadv} = g_rdata;
	logic signed [31:0] x0, y0, x1, y1;
	assign x0 = pen_x_q + 32'(gdx);
	assign y0 = pen_y_q + 32'(gdy);
	assign x1 = x0 + {16'd0, gw};
	assign y1 = y0 + {16'd0, gh};

	// ---- line end ----
	// centring halves the advance, truncating toward zero
	logic signed [31:0] lw, lo, hi;
	assign lw = align_q[0]
		? ($signed(pen_x_q) >>> 1) + $signed({31'd0, pen_x_q[31] & pen_x_q[0]})
		: $signed(pen_x_q);
	assign lo = lmin_q - lw;
	assign hi = lmax_q - lw;

	logic out_full, emit_go;
	assign out_full = out_valid && out_stall;
	assign emit_go = (state_q == StEmit) && !out_full;
	assign in_stall = (state_q != StIdle);
	assign cfg_ready = 1'b1;

	logic [31:0] height;
	assign height = pen_y_q + {16'd0, line_pitch_q};

	function automatic state_t d_next(input logic redo);
		return redo ? StDec : StIdle;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			line_pitch_q <= 16'd16; align_q <= '0; ranges_q <= '0;
			pend_q <= '0; part_q <= '0; pen_x_q <= '0; pen_y_q <= '0;
			lmin_q <= '0; lmax_q <= '0; ink_q <= 1'b0;
			bx0_q <= BoxMinInit; by0_q <= BoxMinInit;
			bx1_q <= BoxMaxInit; by1_q <= BoxMaxInit;
			redo_q <= 1'b0; out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall && !emit_go) out_valid <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					RegLineHeight: line_pitch_q <= cfg_data;
					RegAlign: align_q <= cfg_data[3:0];
					RegRanges: ranges_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			case (state_q)
				StIdle: begin
					if (in_acc && cmd == CmdText) begin
						byte_q <= text_byte; redo_q <= 1'b0; state_q <= StDec;
					end
				end
				StDec: begin
					pend_q <= d_pend; part_q <= d_part; redo_q <= d_redo;
					code_q <= d_val; ri_q <= '0; base_q <= '0;
					if (!d_code) state_q <= StIdle;
					else if (d_val == 16'd0) begin
						after_q <= 2'd3; state_q <= StEnd;
					end else if (d_val == CodeNl) begin
						after_q <= 2'd1; state_q <= StEnd;
					end else if (d_val == CodeHalfNl) begin
						after_q <= 2'd2; state_q <= StEnd;
					end else begin
						after_q <= 2'd0; state_q <= StWalk;
					end
				end
				StWalk: begin
					// one range per visit; read for ri_q issued the cycle before
					if (walk_first) begin
						after_q <= 2'd1; // marks read issued
						if (n_ranges == 5'd0) state_q <= d_next(redo_q);
					end else if (ri_q >= n_ranges || {1'b0, rf} > {1'b0, code_q}) begin
						state_q <= d_next(redo_q);
					end else if ({1'b0, code_q} < r_end) begin
						if (g_sum < 17'(MaxGlyphs)) begin
							gidx_q <= g_sum[GlyphAw-1:0]; state_q <= StGlyph;
						end else state_q <= d_next(redo_q);
					end else begin
						base_q <= base_q + {5'd0, rs}; ri_q <= ri_nxt;
						if (ri_nxt >= n_ranges) state_q <= d_next(redo_q);
					end
				end
				StGlyph: state_q <= StDraw;
				StDraw: begin
					if (gw != 16'd0 && gh != 16'd0) begin
						if (y0 < by0_q) by0_q <= y0;
						if (y1 > by1_q) by1_q <= y1;
						if (align_q[1:0] != 2'd0) begin
							if (!ink_q || x0 < lmin_q) lmin_q <= x0;
							if (!ink_q || x1 > lmax_q) lmax_q <= x1;
							ink_q <= 1'b1;
						end else begin
							if (x0 < bx0_q) bx0_q <= x0;
							if (x1 > bx1_q) bx1_q <= x1;
						end
					end
					pen_x_q <= pen_x_q + 32'(gadv);
					state_q <= d_next(redo_q);
				end
				StEnd: begin
					if (align_q[1:0] != 2'd0 && ink_q) begin
						if (lo < bx0_q) bx0_q <= lo;
						if (hi > bx1_q) bx1_q <= hi;
					end
					ink_q <= 1'b0; lmin_q <= '0; lmax_q <= '0; pen_x_q <= '0;
					if (after_q == 2'd1) begin
						pen_y_q <= pen_y_q + {16'd0, line_pitch_q}; state_q <= d_next(redo_q);
					end else if (after_q == 2'd2) begin
						pen_y_q <= pen_y_q + {17'd0, line_pitch_q[15:1]};
						state_q <= d_next(redo_q);
					end else state_q <= StEmit;
				end
				StEmit: begin
					if (emit_go) begin
						out_valid <= 1'b1;
						box_width <= (bx0_q < bx1_q) ? ((bx1_q - bx0_q + 32'd7) & ~32'd7) : '0;
						box_height <= (by0_q < by1_q) ? ((by1_q - by0_q + 32'd7) & ~32'd7) : '0;
						origin_x <= bx0_q; origin_y <= by0_q;
						case (align_q[3:2])
							2'd1: baseline_offset <= {1'b0, height[31:1]};
							2'd2: baseline_offset <= height;
							default: baseline_offset <= '0;
						endcase
						pend_q <= '0; part_q <= '0; pen_y_q <= '0; redo_q <= 1'b0;
						bx0_q <= BoxMinInit; by0_q <= BoxMinInit;
						bx1_q <= BoxMaxInit; by1_q <= BoxMaxInit;
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	`TEM_ASSERT_IMP(a_stall_busy, clk, arst_n, state_q != StIdle, in_stall,
		"input taken while busy")
	`TEM_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid,
		"result dropped under stall")
	`TEM_ASSERT_IMP(a_walk_bound, clk, arst_n, state_q == StWalk,
		ri_q <= 5'(MaxRanges), "range walk overran")
endmodule

// ----- dv/text_extents_measure_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_extents_measure_unit_tb
// Self-checking bench for the text extents measure unit. Loads code ranges
// and glyph metrics, streams UTF-8 strings through the text channel and
// checks every emitted box against an in-bench model of the measurement.
// ----------------------------------------------------------------------------
module text_extents_measure_unit_tb;
	import tem_pkg::*;

	// cmd 3 has no meaning; the block must drop it
	localparam logic [1:0] CmdNone = 2'd3;
	localparam int RangeBudget = 32;	// glyph entries reachable through ranges
	localparam int HoldCycles = 400;
	localparam int SettleCycles = 64;
	localparam int WatchLimit = 20000;

	typedef struct packed {
		logic [15:0] w, h, dx, dy, adv;
	} metrics_t;

	typedef struct {
		logic [1:0]  cmd;
		logic [9:0]  slot;
		logic [7:0]  b;
		logic [15:0] first;
		logic [10:0] size;
		metrics_t    m;
	} item_t;

	typedef struct {
		logic [31:0] w, h, ox, oy, base;
	} box_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_stall;
	logic [1:0] cmd;
	logic [9:0] slot;
	logic [7:0] text_byte;
	logic [15:0] range_first;
	logic [10:0] range_size;
	logic [15:0] glyph_width, glyph_height;
	logic signed [15:0] glyph_dx, glyph_dy, glyph_advance;
	logic out_valid, out_stall;
	logic [31:0] box_width, box_height, baseline_offset;
	logic signed [31:0] origin_x, origin_y;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	text_extents_measure_unit uut (.*);

	initial forever #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Model state: tables, registers and the text measurement state
	// ------------------------------------------------------------------
	logic [15:0] rng_first [MaxRanges];
	logic [10:0] rng_size [MaxRanges];
	metrics_t glyphs [MaxGlyphs];
	logic [15:0] line_h;
	logic [3:0] align;
	logic [4:0] n_rng;
	int pend;
	logic [15:0] partial;
	logic [31:0] pen_x, pen_y;
	logic signed [31:0] ink_lo, ink_hi;
	bit ink;
	logic signed [31:0] bx0, by0, bx1, by1;	// min x, min y, max x, max y

	box_t boxes_due [$];
	int n_err = 0;
	int n_items = 0;
	int n_boxes = 0;
	bit idle_en = 1'b1;
	bit hold_req = 1'b0;

	task automatic clear_text();
		pend = 0;
		partial = '0;
		pen_x = '0;
		pen_y = '0;
		ink_lo = '0;
		ink_hi = '0;
		ink = 1'b0;
		bx0 = BoxMinInit;
		by0 = BoxMinInit;
		bx1 = BoxMaxInit;
		by1 = BoxMaxInit;
	endtask

	// Line end: with alignment on, the line's ink span is shifted back by
	// the (possibly halved) pen advance before it joins the box.
	task automatic close_line();
		logic signed [31:0] shift, lo, hi;
		if (align[1:0] != 2'd0) begin
			shift = pen_x;
			if (align[0])
				shift = shift / 2;
			if (ink) begin
				lo = ink_lo - shift;
				hi = ink_hi - shift;
				if (lo < bx0) bx0 = lo;
				if (hi > bx1) bx1 = hi;
			end
		end
		ink = 1'b0;
		ink_lo = '0;
		ink_hi = '0;
		pen_x = '0;
	endtask

	function automatic bit glyph_index(input logic [15:0] code, output int idx);
		int unsigned n, base, f, s;
		n = (n_rng > MaxRanges) ? MaxRanges : n_rng;
		base = 0;
		for (int i = 0; i < n; i++) begin
			f = rng_first[i];
			s = rng_size[i];
			if (f > code)
				return 1'b0;
			if (code < f + s) begin
				idx = base + (code - f);
				return idx < MaxGlyphs;
			end
			base += s;
		end
		return 1'b0;
	endfunction

	task automatic place_glyph(input metrics_t g);
		logic signed [31:0] x0, y0, x1, y1;
		if (g.w != 0 && g.h != 0) begin
			x0 = pen_x + {{16{g.dx[15]}}, g.dx};
			y0 = pen_y + {{16{g.dy[15]}}, g.dy};
			x1 = x0 + {16'd0, g.w};
			y1 = y0 + {16'd0, g.h};
			if (y0 < by0) by0 = y0;
			if (y1 > by1) by1 = y1;
			if (align[1:0] != 2'd0) begin
				if (!ink || x0 < ink_lo) ink_lo = x0;
				if (!ink || x1 > ink_hi) ink_hi = x1;
				ink = 1'b1;
			end else begin
				if (x0 < bx0) bx0 = x0;
				if (x1 > bx1) bx1 = x1;
			end
		end
		pen_x += {{16{g.adv[15]}}, g.adv};
	endtask

	task automatic measure_code(input logic [15:0] code);
		box_t r;
		logic [31:0] height;
		int idx;
		if (code == 16'd0) begin
			close_line();
			height = pen_y + {16'd0, line_h};
			r.w = (bx0 < bx1) ? ((bx1 - bx0 + 32'd7) & ~32'd7) : 32'd0;
			r.h = (by0 < by1) ? ((by1 - by0 + 32'd7) & ~32'd7) : 32'd0;
			r.ox = bx0;
			r.oy = by0;
			case (align[3:2])
				2'd1: r.base = height >> 1;
				2'd2: r.base = height;
				default: r.base = '0;
			endcase
			boxes_due.push_back(r);
			clear_text();
		end else if (code == CodeNl || code == CodeHalfNl) begin
			close_line();
			pen_y += (code == CodeHalfNl) ? {17'd0, line_h[15:1]} : {16'd0, line_h};
		end else if (glyph_index(code, idx)) begin
			place_glyph(glyphs[idx]);
		end
	endtask

	task automatic measure_item(input item_t it);
		logic [7:0] b;
		b = it.b;
		case (it.cmd)
			CmdRange: if (it.slot < MaxRanges) begin
				rng_first[it.slot] = it.first;
				rng_size[it.slot] = it.size;
			end
			CmdGlyph: glyphs[it.slot] = it.m;
			CmdText: begin
				if (pend != 0) begin
					if (b == 8'd0) begin
						pend = 0;
						measure_code(16'd0);
						return;
					end
					if (b[7:6] == 2'b10) begin
						partial = {partial[9:0], b[5:0]};
						pend--;
						if (pend == 0)
							measure_code(partial);
						return;
					end
					// broken sequence: '?' then the byte starts over
					pend = 0;
					measure_code(CodeBad);
				end
				if (!b[7])
					measure_code({8'd0, b});
				else if (b[7:5] == 3'b110) begin
					pend = 1;
					partial = {11'd0, b[4:0]};
				end else if (b[7:4] == 4'b1110) begin
					pend = 2;
					partial = {12'd0, b[3:0]};
				end else
					measure_code(CodeBad);
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	task automatic send(input item_t it);
		cmd <= it.cmd;
		slot <= it.slot;
		text_byte <= it.b;
		range_first <= it.first;
		range_size <= it.size;
		glyph_width <= it.m.w;
		glyph_height <= it.m.h;
		glyph_dx <= it.m.dx;
		glyph_dy <= it.m.dy;
		glyph_advance <= it.m.adv;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		measure_item(it);
		n_items++;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		item_t it;
		it = '{cmd: CmdText, slot: 10'($urandom), b: b, first: 16'($urandom),
			size: 11'($urandom), m: metrics_t'({$urandom, $urandom, $urandom})};
		send(it);
	endtask

	task automatic send_range(input logic [9:0] s, input logic [15:0] f,
			input logic [10:0] sz);
		item_t it;
		it = '{cmd: CmdRange, slot: s, b: 8'($urandom), first: f, size: sz,
			m: metrics_t'({$urandom, $urandom, $urandom})};
		send(it);
	endtask

	task automatic send_glyph(input logic [9:0] s, input metrics_t m);
		item_t it;
		it = '{cmd: CmdGlyph, slot: s, b: 8'($urandom), first: 16'($urandom),
			size: 11'($urandom), m: m};
		send(it);
	endtask

	// UTF-8 encode, shortest form, up to 3 bytes
	task automatic send_code(input logic [15:0] c);
		if (c < 16'h80)
			send_byte(c[7:0]);
		else if (c < 16'h800) begin
			send_byte({3'b110, c[10:6]});
			send_byte({2'b10, c[5:0]});
		end else begin
			send_byte({4'b1110, c[15:12]});
			send_byte({2'b10, c[11:6]});
			send_byte({2'b10, c[5:0]});
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] d);
		cfg_index <= idx;
		cfg_data <= d;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			RegLineHeight: line_h = d;
			RegAlign: align = d[3:0];
			RegRanges: n_rng = d[4:0];
			default: ;
		endcase
	endtask

	// Wait out every pending box, then let any box-less byte finish too
	task automatic drain();
		in_valid <= 1'b0;
		while (boxes_due.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	function automatic metrics_t rand_metrics();
		metrics_t m;
		m.w = ($urandom_range(0, 6) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
		m.h = ($urandom_range(0, 6) == 0) ? 16'd0 : 16'($urandom_range(1, 16));
		m.dx = 16'($signed($urandom_range(0, 6)) - 3);
		m.dy = 16'(-$signed($urandom_range(0, 14)));
		m.adv = 16'($urandom_range(0, 12));
		if ($urandom_range(0, 9) == 0)
			m = metrics_t'({$urandom, $urandom, $urandom});
		return m;
	endfunction

	// A code that lands in a loaded range most of the time
	function automatic logic [15:0] mapped_code();
		int i;
		i = $urandom_range(0, MaxRanges - 1);
		if (rng_size[i] == 0)
			return 16'($urandom_range(16'h20, 16'h7E));
		return rng_first[i] + 16'($urandom_range(0, rng_size[i] - 1));
	endfunction

	// Range reload that keeps every reachable glyph entry inside the
	// loaded part of the store; slots past the table take any size.
	task automatic reload_range();
		int s, used, room;
		s = $urandom_range(0, 3) == 0 ? $urandom_range(MaxRanges, 1023)
			: $urandom_range(0, MaxRanges - 1);
		if (s >= MaxRanges)
			send_range(s, 16'($urandom), 11'($urandom_range(0, 1024)));
		else begin
			used = 0;
			foreach (rng_size[i]) if (i != s) used += rng_size[i];
			room = RangeBudget - used;
			send_range(s, 16'($urandom), 11'($urandom_range(0, room)));
		end
	endtask

	// One string of random content, mostly well formed, closed by NUL
	task automatic random_string();
		int len, r;
		len = $urandom_range(0, 8);
		repeat (len) begin
			r = $urandom_range(0, 99);
			if (r < 55) send_code(mapped_code());
			else if (r < 63) send_byte(CodeNl[7:0]);
			else if (r < 67) send_byte(CodeHalfNl[7:0]);
			else if (r < 73) send_code(16'($urandom_range(1, 16'hFFFF)));
			else if (r < 80) send_byte(8'($urandom_range(1, 255)));
			else if (r < 84) begin
				// lead byte cut short by a plain character
				send_byte(8'($urandom_range(8'hC2, 8'hEF)));
				send_byte(8'($urandom_range(8'h21, 8'h7E)));
			end else if (r < 90) send_glyph($urandom_range(0, 1023), rand_metrics());
			else if (r < 95) reload_range();
			else begin
				item_t it;
				it = '{cmd: CmdNone, slot: 10'($urandom), b: 8'($urandom),
					first: 16'($urandom), size: 11'($urandom),
					m: metrics_t'({$urandom, $urandom, $urandom})};
				send(it);
			end
		end
		send_byte(8'd0);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	localparam logic [15:0] SetupFirst [MaxRanges] = '{16'h20, 16'h41, 16'h61,
		16'hA0, 16'h3B1, 16'h7FF, 16'h800, 16'h4E00, 16'h5000, 16'h6000, 16'h7000,
		16'h8000, 16'hA000, 16'hC000, 16'hE000, 16'hFFFF};
	localparam int SetupSize [MaxRanges] = '{4, 3, 2, 2, 2, 1, 2, 2, 0, 2, 2, 2, 2,
		2, 2, 1};

	task automatic test_table_load();
		metrics_t m;
		for (int i = 0; i < RangeBudget; i++) begin
			m = rand_metrics();
			case (i)
				0: m = '{w: 16'd0, h: 16'd8, dx: 16'd0, dy: 16'd0, adv: 16'd6};
				1: m = '{w: 16'd5, h: 16'd0, dx: 16'd0, dy: 16'd0, adv: 16'd6};
				2: m = '{w: 16'hFFFF, h: 16'hFFFF, dx: 16'h8000, dy: 16'h8000,
					adv: 16'h7FFF};
				3: m = '{w: 16'd6, h: 16'd9, dx: 16'h7FFF, dy: 16'h7FFF, adv: 16'h8000};
				default: ;
			endcase
			send_glyph(i, m);
		end
		foreach (SetupFirst[i])
			send_range(i, SetupFirst[i], 11'(SetupSize[i]));
		// a range load past the table is dropped; glyph slot 1023 is the store's last entry
		send_range(10'd1023, 16'hFFFF, 11'd1024);
		send_glyph(10'd1023, '1);
		drain();
		write_reg(RegRanges, 16'd16);
	endtask

	task automatic test_directed_text();
		send_code(16'h20);	// blank glyph, advance only
		send_code(16'h22);	// widest, most negative offsets
		send_byte(8'd0);
		send_code(16'h41);
		send_byte(CodeNl[7:0]);
		send_code(16'h42);
		send_byte(CodeHalfNl[7:0]);
		send_code(16'h23);
		send_code(16'h3B1);	// two-byte form
		send_code(16'h7FF);
		send_code(16'h4E00);	// three-byte form
		send_code(16'hFFFF);
		send_code(16'h30);	// no range holds it
		send_byte(8'd0);
		send_byte(8'h80);	// stray continuation as lead
		send_byte(8'hF5);	// four-byte lead is not accepted
		send_byte(8'hC3);
		send_byte(8'h41);	// broken sequence, then a plain 'A'
		send_byte(8'd0);
		send_byte(8'hE4);
		send_byte(8'd0);	// NUL inside a sequence
		send_byte(8'hC0);
		send_byte(8'h80);	// overlong zero ends the string
		send_byte(8'd0);	// empty string
	endtask

	task automatic test_settings_sweep();
		int stop;
		logic [15:0] lh, nr;
		for (int p = 0; p < 16; p++) begin
			drain();
			if (p == 13)
				idle_en = 1'b0;	// closing stretch runs flat out
			lh = (p == 1) ? 16'd0 : (p == 2) ? 16'hFFFF
				: 16'($urandom_range(1, 40));
			nr = (p == 3) ? 16'd0 : (p == 5) ? 16'd31 : (p == 7) ? 16'd1
				: 16'($urandom_range(8, 16));
			write_reg(RegLineHeight, lh);
			write_reg(RegAlign, 16'(p));
			write_reg(RegRanges, nr);
			stop = n_items + 45;
			while (n_items < stop)
				random_string();
		end
	endtask

	// Receiver holds off while strings keep coming, so the block backs up
	task automatic test_backpressure();
		drain();
		write_reg(RegAlign, 16'd9);
		hold_req = 1'b1;
		repeat (12) random_string();
		drain();
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stall bursts, or one long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (idle_en && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got);
		if (got !== exp_v) begin
			$error("%s: expected %0d (0x%08h), got %0d (0x%08h)", name,
				$signed(exp_v), exp_v, $signed(got), got);
			n_err++;
		end
	endtask

	// Box checker: every accepted result against the oldest prediction
	always @(posedge clk) begin
		box_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (boxes_due.size() == 0) begin
				$error("box result with no string ended");
				n_err++;
			end else begin
				e = boxes_due.pop_front();
				check_field("box_width", e.w, box_width);
				check_field("box_height", e.h, box_height);
				check_field("origin_x", e.ox, origin_x);
				check_field("origin_y", e.oy, origin_y);
				check_field("baseline_offset", e.base, baseline_offset);
				n_boxes++;
			end
		end
	end

	// Watchdog: too long with nothing moving on any channel
	int quiet = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet == WatchLimit) begin
			$display("timeout: no progress for %0d cycles", WatchLimit);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid <= 1'b0;
		cmd <= CmdText;
		slot <= '0;
		text_byte <= '0;
		range_first <= '0;
		range_size <= '0;
		glyph_width <= '0;
		glyph_height <= '0;
		glyph_dx <= '0;
		glyph_dy <= '0;
		glyph_advance <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= RegLineHeight;
		cfg_data <= '0;
		line_h = 16'd16;
		align = '0;
		n_rng = '0;
		foreach (rng_first[i]) begin
			rng_first[i] = '0;
			rng_size[i] = '0;
		end
		clear_text();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_load();
		test_directed_text();
		test_backpressure();
		test_settings_sweep();

		drain();
		if (boxes_due.size() != 0) begin
			$error("%0d boxes never arrived", boxes_due.size());
			n_err++;
		end
		$display("covered %0d items and %0d measured strings over all 16 align modes,",
			n_items, n_boxes);
		$display("line heights 0 to 65535, range counts 0 to 31, with stalls on both sides");
		if (n_err == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
